### design/tsdt_pkg.sv
// Shared types and constants of the tolerant set de-duplication table.
package tsdt_pkg;

	localparam int VAL_W     = 52;
	localparam int TOL_W     = 21;
	localparam int CNT_W     = 11;
	localparam int CAPACITY  = 1024;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

endpackage

### design/tsdt_ifs.sv
// Handshake channels of the de-duplication table: elements, results and configuration.
interface tsdt_elem_if;
	logic                             valid;
	logic                             ready;
	logic signed [tsdt_pkg::VAL_W-1:0] value;
	logic                             last_item;

	modport source (output valid, value, last_item, input ready);
	modport sink   (input valid, value, last_item, output ready);
endinterface

interface tsdt_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [tsdt_pkg::VAL_W-1:0] value_out;
	logic                             added;
	logic                             dropped_full;
	logic [tsdt_pkg::CNT_W-1:0]       unique_count;
	logic                             set_done;

	modport source (output valid, value_out, added, dropped_full, unique_count, set_done,
		input ready);
	modport sink   (input valid, value_out, added, dropped_full, unique_count, set_done,
		output ready);
endinterface

interface tsdt_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tsdt_pkg::TOL_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

### design/tolerant_set_dedup_table.sv
// Tolerant set de-duplication table: top level with scan sequencer and table RAM.
// Each element walks the stored entries one per cycle through a read, subtract and compare
// pipeline, stopping at the first match. A new element is taken only when the sequencer is
// idle again, after the previous one has been decided; while an earlier result is held
// un-taken on the result channel, the sequencer waits in its decide state.
// Reset clears the count and sequencer, sets the tolerance to 10 and leaves the table as is.
module tolerant_set_dedup_table #(
	parameter int CAPACITY = tsdt_pkg::CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	tsdt_cfg_if.sink  cfg,
	tsdt_elem_if.sink elements,
	tsdt_res_if.source results
);

	localparam int VW = tsdt_pkg::VAL_W;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > tsdt_pkg::CNT_W) ? CW : tsdt_pkg::CNT_W;

	tsdt_pkg::state_t state_q, state_d;

	logic [tsdt_pkg::TOL_W-1:0] tol_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              rd_idx_q;
	logic [VW-1:0]              value_q;
	logic                       last_q;
	logic                       match_q;

	logic          rd_vld_s1;
	logic          diff_vld_s2;
	logic [VW:0]   diff_s2;

	logic [VW-1:0] rd_data;
	logic          rd_en;
	logic          wr_en;
	logic          accept;
	logic          hit;
	logic          drained;
	logic          scan_end;
	logic          decide_fire;
	logic          room;

	logic [VW:0]   diff;
	logic [VW:0]   tol_x;
	logic [VW:0]   tol_sum;
	logic [CW-1:0] cnt_new;
	logic [XW-1:0] cnt_x;

	logic                       out_vld_q;
	logic [VW-1:0]              out_value_q;
	logic                       out_added_q;
	logic                       out_dropped_q;
	logic [tsdt_pkg::CNT_W-1:0] out_count_q;
	logic                       out_done_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= tsdt_pkg::TOL_RESET;
		end else if (cfg.valid) begin
			tol_q <= cfg.data;
		end
	end

	// Compare path: read data is registered in the RAM, the difference in the next stage.
	assign diff    = {rd_data[VW-1], rd_data} - {value_q[VW-1], value_q};
	assign tol_x   = (VW+1)'(tol_q);
	assign tol_sum = diff_s2 + tol_x;

	// A negative difference is within tolerance when adding the tolerance makes it positive.
	always_comb begin
		if (!diff_s2[VW]) begin
			hit = diff_vld_s2 && (diff_s2 < tol_x);
		end else begin
			hit = diff_vld_s2 && !tol_sum[VW] && (tol_sum != '0);
		end
	end

	assign drained  = (rd_idx_q == cnt_q) && !rd_vld_s1 && !diff_vld_s2;
	assign scan_end = (state_q == tsdt_pkg::ST_SCAN) && (hit || drained);
	assign room     = cnt_q < CW'(CAPACITY);
	assign cnt_new  = cnt_q + CW'(wr_en);
	assign cnt_x    = XW'(cnt_new);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tsdt_pkg::ST_IDLE: begin
				if (elements.valid) begin
					state_d = tsdt_pkg::ST_SCAN;
				end
			end
			tsdt_pkg::ST_SCAN: begin
				if (hit || drained) begin
					state_d = tsdt_pkg::ST_DECIDE;
				end
			end
			tsdt_pkg::ST_DECIDE: begin
				if (!out_vld_q || results.ready) begin
					state_d = tsdt_pkg::ST_IDLE;
				end
			end
			default: state_d = tsdt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		elements.ready = 1'b0;
		rd_en          = 1'b0;
		decide_fire    = 1'b0;
		case (state_q)
			tsdt_pkg::ST_IDLE:   elements.ready = 1'b1;
			tsdt_pkg::ST_SCAN:   rd_en = (rd_idx_q < cnt_q) && !hit;
			tsdt_pkg::ST_DECIDE: decide_fire = !out_vld_q || results.ready;
			default: begin
				elements.ready = 1'b0;
			end
		endcase
	end

	assign accept = elements.valid && elements.ready;
	assign wr_en  = decide_fire && !match_q && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsdt_pkg::ST_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			diff_vld_s2 <= 1'b0;
			match_q     <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (state_q != tsdt_pkg::ST_SCAN || scan_end) begin
				rd_vld_s1   <= 1'b0;
				diff_vld_s2 <= 1'b0;
			end else begin
				rd_vld_s1   <= rd_en;
				diff_vld_s2 <= rd_vld_s1;
			end
			if (scan_end) begin
				match_q <= hit;
			end
			if (decide_fire) begin
				cnt_q <= last_q ? '0 : cnt_new;
			end
			out_vld_q <= decide_fire || (out_vld_q && !results.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= elements.value;
			last_q  <= elements.last_item;
		end
		diff_s2 <= diff;
		if (decide_fire) begin
			out_value_q   <= value_q;
			out_added_q   <= wr_en;
			out_dropped_q <= !match_q && !room;
			out_done_q    <= last_q;
			if (cnt_x > XW'(tsdt_pkg::CNT_MAX)) begin
				out_count_q <= tsdt_pkg::CNT_MAX;
			end else begin
				out_count_q <= tsdt_pkg::CNT_W'(cnt_x);
			end
		end
	end

	tsdt_ram #(
		.WIDTH (VW),
		.DEPTH (CAPACITY)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (value_q),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign results.valid        = out_vld_q;
	assign results.value_out    = out_value_q;
	assign results.added        = out_added_q;
	assign results.dropped_full = out_dropped_q;
	assign results.unique_count = out_count_q;
	assign results.set_done     = out_done_q;

endmodule

### design/tsdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tsdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### test/tb_top.sv
// Self-checking testbench for the tolerant set de-duplication table.
module tb_top;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_PRINTED    = 50;
	localparam logic signed [tsdt_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(tsdt_pkg::VAL_W-1){1'b0}}};
	localparam logic signed [tsdt_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(tsdt_pkg::VAL_W-1){1'b1}}};

	typedef struct {
		logic signed [tsdt_pkg::VAL_W-1:0] value;
		logic                              last;
	} elem_item_t;

	typedef struct {
		logic signed [tsdt_pkg::VAL_W-1:0] value_out;
		logic                              added;
		logic                              dropped_full;
		logic [tsdt_pkg::CNT_W-1:0]        unique_count;
		logic                              set_done;
	} dedup_res_t;

	logic clk;
	logic arst_n;

	tsdt_cfg_if  cfg_ch ();
	tsdt_elem_if elem_ch ();
	tsdt_res_if  res_ch ();

	tolerant_set_dedup_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.elements (elem_ch),
		.results  (res_ch)
	);

	// Shadow copy of the table, the count and the tolerance register.
	logic signed [tsdt_pkg::VAL_W-1:0] kept_vals [tsdt_pkg::CAPACITY];
	int                                kept_count;
	logic [tsdt_pkg::TOL_W-1:0]        tol_model;

	elem_item_t pending_elems [$];
	dedup_res_t predicted_outcomes [$];
	elem_item_t drv_item;
	dedup_res_t want;

	int  items_queued, items_accepted, results_seen, mismatches;
	int  added_total, dup_total, dropped_total, sets_total, settings_total;
	int  quiet_cycles, elem_gap, res_gap;
	bit  elem_taken, idle_on;
	bit  cfg_fire, elem_fire, res_fire;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dedup_res_t judge_element(logic signed [tsdt_pkg::VAL_W-1:0] v,
		logic last);
		dedup_res_t r;
		logic       hit;
		longint     spread;
		longint     tl;
		hit = 1'b0;
		tl  = tol_model;
		for (int i = 0; i < kept_count && !hit; i++) begin
			spread = longint'(kept_vals[i]) - longint'(v);
			if (spread < 0)
				spread = -spread;
			if (spread < tl)
				hit = 1'b1;
		end
		r.value_out    = v;
		r.added        = 1'b0;
		r.dropped_full = 1'b0;
		if (hit) begin
			dup_total++;
		end else if (kept_count < tsdt_pkg::CAPACITY) begin
			kept_vals[kept_count] = v;
			kept_count++;
			r.added = 1'b1;
			added_total++;
		end else begin
			r.dropped_full = 1'b1;
			dropped_total++;
		end
		r.unique_count = (kept_count > tsdt_pkg::CNT_MAX) ? tsdt_pkg::CNT_MAX :
			tsdt_pkg::CNT_W'(kept_count);
		r.set_done     = last;
		if (last) begin
			kept_count = 0;
			sets_total++;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch on result %0d: %s got %h, wanted %h", results_seen, what, got,
				wanted);
	endtask

	task automatic push_elem(longint v, bit last);
		elem_item_t it;
		it.value = v[tsdt_pkg::VAL_W-1:0];
		it.last  = last;
		pending_elems.push_back(it);
		items_queued++;
	endtask

	task automatic drain();
		while (items_accepted != items_queued || predicted_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_tolerance(logic [tsdt_pkg::TOL_W-1:0] t);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= t;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_total++;
	endtask

	function automatic longint fresh_anchor();
		if ($urandom_range(0, 1) == 0)
			return longint'(int'($urandom_range(0, 8192))) - 4096;
		return longint'({$urandom, $urandom});
	endfunction

	// Mostly values close to one of the set's anchors, so that matches and near misses
	// around the tolerance are common; the rest are wild values, the range ends and values near zero.
	function automatic longint near_or_wild(longint anchor, int span);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 15)
			return longint'({$urandom, $urandom});
		if (sel < 22) begin
			case ($urandom_range(0, 5))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return VAL_MIN + 1;
				3: return VAL_MAX - 1;
				4: return -1;
				default: return 0;
			endcase
		end
		return anchor + longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic random_phase(int quota);
		int     made, len, n_anchor, span;
		longint anchors [4];
		made = 0;
		while (made < quota) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: len = $urandom_range(1, 3);
				6:                len = $urandom_range(100, 200);
				default:          len = $urandom_range(4, 40);
			endcase
			n_anchor = $urandom_range(1, 4);
			for (int a = 0; a < 4; a++)
				anchors[a] = fresh_anchor();
			span = int'(tol_model) + 3;
			for (int k = 0; k < len; k++)
				push_elem(near_or_wild(anchors[$urandom_range(0, n_anchor - 1)], span),
					k == len - 1);
			made += len;
		end
	endtask

	function automatic logic [tsdt_pkg::TOL_W-1:0] pick_tolerance();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return tsdt_pkg::TOL_W'(1);
			2: return tsdt_pkg::TOL_RESET;
			3: return tsdt_pkg::TOL_W'(1048576);
			4: return '1;
			5: return tsdt_pkg::TOL_W'($urandom_range(0, 1048576));
			default: return tsdt_pkg::TOL_W'($urandom);
		endcase
	endfunction

	// Driver: a held item stays on the channel until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!elem_ch.valid || elem_taken) begin
				elem_taken = 1'b0;
				if (elem_gap > 0) begin
					elem_gap--;
					elem_ch.valid <= 1'b0;
				end else if (pending_elems.size() != 0) begin
					if (idle_on && $urandom_range(0, 9) == 0) begin
						elem_gap = $urandom_range(0, 15);
						elem_ch.valid <= 1'b0;
					end else begin
						drv_item = pending_elems.pop_front();
						elem_ch.valid     <= 1'b1;
						elem_ch.value     <= drv_item.value;
						elem_ch.last_item <= drv_item.last;
					end
				end else begin
					elem_ch.valid <= 1'b0;
				end
			end
			if (res_gap > 0) begin
				res_gap--;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				res_gap = $urandom_range(0, 15);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on every accepted element and checks every accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			cfg_fire  = cfg_ch.valid && cfg_ch.ready;
			elem_fire = elem_ch.valid && elem_ch.ready;
			res_fire  = res_ch.valid && res_ch.ready;
			if (cfg_fire)
				tol_model = cfg_ch.data;
			if (elem_fire) begin
				predicted_outcomes.push_back(judge_element(elem_ch.value, elem_ch.last_item));
				items_accepted++;
				elem_taken = 1'b1;
			end
			if (res_fire) begin
				results_seen++;
				if (predicted_outcomes.size() == 0) begin
					report_mismatch("unexpected result, value_out", res_ch.value_out, '0);
				end else begin
					want = predicted_outcomes.pop_front();
					if (res_ch.value_out !== want.value_out)
						report_mismatch("value_out", res_ch.value_out, want.value_out);
					if (res_ch.added !== want.added)
						report_mismatch("added", res_ch.added, want.added);
					if (res_ch.dropped_full !== want.dropped_full)
						report_mismatch("dropped_full", res_ch.dropped_full, want.dropped_full);
					if (res_ch.unique_count !== want.unique_count)
						report_mismatch("unique_count", res_ch.unique_count, want.unique_count);
					if (res_ch.set_done !== want.set_done)
						report_mismatch("set_done", res_ch.set_done, want.set_done);
				end
			end
			if (cfg_fire || elem_fire || res_fire) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles, %0d of %0d items taken",
						quiet_cycles, items_accepted, items_queued);
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		elem_ch.valid     = 1'b0;
		elem_ch.value     = '0;
		elem_ch.last_item = 1'b0;
		res_ch.ready      = 1'b0;
		tol_model         = tsdt_pkg::TOL_RESET;
		kept_count        = 0;
		idle_on           = 1'b1;
		settings_total    = 1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Tolerance left at its reset value: matches just inside and just outside it,
		// and both ends of the value range.
		push_elem(0, 0);
		push_elem(9, 0);
		push_elem(10, 0);
		push_elem(VAL_MIN, 0);
		push_elem(VAL_MAX, 0);
		push_elem(VAL_MIN + 5, 0);
		push_elem(VAL_MAX - 9, 0);
		push_elem(-10, 0);
		push_elem(-19, 0);
		push_elem(0, 1);
		push_elem(123, 1);
		drain();

		// With zero tolerance even identical values are all kept.
		write_tolerance('0);
		push_elem(5, 0);
		push_elem(5, 0);
		push_elem(5, 1);
		drain();

		// Tolerance above the stated range is used as written.
		write_tolerance('1);
		push_elem(0, 0);
		push_elem(2097150, 0);
		push_elem(2097151, 0);
		push_elem(-2097151, 1);
		drain();

		write_tolerance(tsdt_pkg::TOL_W'(1048576));
		push_elem(0, 0);
		push_elem(1048575, 0);
		push_elem(1048576, 0);
		push_elem(VAL_MAX, 1);
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 7)
				idle_on = 1'b0;
			write_tolerance(pick_tolerance());
			random_phase(55);
			drain();
		end

		repeat (tsdt_pkg::CAPACITY + 8) @(posedge clk);
		if (predicted_outcomes.size() != 0)
			report_mismatch("results never delivered", predicted_outcomes.size(), 0);

		$display("Ran %0d elements in %0d sets under %0d tolerance settings.",
			items_accepted, sets_total, settings_total);
		$display("Outcomes: %0d kept, %0d matched, %0d dropped on a full table; %0d mismatches.",
			added_total, dup_total, dropped_total, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
